// File: design/assert_macros.svh
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define Q2E_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("q2e: same-cycle check failed");

// Next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("q2e: next-cycle check failed");

`endif

// File: design/q2e_pkg.sv
package q2e_pkg;

    localparam int IN_W       = 16;
    localparam int MAT_W      = 35;
    localparam int CRD_W      = 38;
    localparam int ANG_W      = 30;
    localparam int ANG_BITS   = 20;
    localparam int TABLE_LEN  = 24;
    localparam int SQ_W       = 57;
    localparam int SQRT_STEPS = 29;
    localparam int S_W        = 30;
    localparam int UNIT_SHIFT = 28;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    localparam logic signed [ANG_W-1:0] Z90 = ANG_W'(90 * (1 << ANG_BITS));

    typedef struct packed {
        logic signed [MAT_W-1:0] a31;
        logic signed [MAT_W-1:0] a33;
        logic signed [MAT_W-1:0] a12;
        logic signed [MAT_W-1:0] a22;
        logic signed [S_W-1:0]   s;
    } q2e_carry_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } q2e_sqrt_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } q2e_cordic_t;

    // atan(2^-i) in degrees, units of 2^-20
    function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
        logic signed [ANG_W-1:0] t;
        begin
            case (idx)
                0:  t = ANG_W'(47185920);
                1:  t = ANG_W'(27855475);
                2:  t = ANG_W'(14718068);
                3:  t = ANG_W'(7471121);
                4:  t = ANG_W'(3750058);
                5:  t = ANG_W'(1876857);
                6:  t = ANG_W'(938658);
                7:  t = ANG_W'(469357);
                8:  t = ANG_W'(234682);
                9:  t = ANG_W'(117342);
                10: t = ANG_W'(58671);
                11: t = ANG_W'(29335);
                12: t = ANG_W'(14668);
                13: t = ANG_W'(7334);
                14: t = ANG_W'(3667);
                15: t = ANG_W'(1833);
                16: t = ANG_W'(917);
                17: t = ANG_W'(458);
                18: t = ANG_W'(229);
                19: t = ANG_W'(115);
                20: t = ANG_W'(57);
                21: t = ANG_W'(29);
                22: t = ANG_W'(14);
                23: t = ANG_W'(7);
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // quarter-turn so the vector lands in the right half-plane
    function automatic q2e_cordic_t prerot(input logic signed [CRD_W-1:0] y,
                                           input logic signed [CRD_W-1:0] x);
        q2e_cordic_t r;
        begin
            r.zero = (x == '0) && (y == '0);
            if (!y[CRD_W-1]) begin
                r.x = y;
                r.y = -x;
                r.z = Z90;
            end else begin
                r.x = -y;
                r.y = x;
                r.z = -Z90;
            end
            return r;
        end
    endfunction

endpackage

// File: design/quaternion_to_euler.sv
// Quaternion (Q2.14 w, x, y, z) to roll, pitch and yaw in 2^-ANGLE_FRAC_BITS degree.
// Fully pipelined: one transfer in and one out per cycle unless the result register
// is stalled, when the whole pipe holds. Registers: two for the matrix terms, one
// squaring stage, 29 square-root cells for the pitch cosine, one pre-rotation stage,
// one CORDIC cell per stage (at most TABLE_LEN) for each angle, the result register.
// Pitch saturates at +-90 degrees, roll at +-180, yaw wraps into [-180, 180).
module quaternion_to_euler
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    localparam int ROLL_W  = 9 + ANGLE_FRAC_BITS,
    localparam int PITCH_W = 8 + ANGLE_FRAC_BITS,
    localparam int YAW_W   = 9 + ANGLE_FRAC_BITS,
    localparam int TD_W    = ((ROLL_W + PITCH_W + YAW_W + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [63:0]     s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [TD_W-1:0] m_tdata   // roll_angle, pitch_angle, yaw_angle
);

    localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int PIPE = 3 + SQRT_STEPS + 1 + NSTG;
    localparam int SH   = ANG_BITS - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W:0] RND  = (ANG_W + 1)'(1) <<< (SH - 1);
    localparam logic signed [ANG_W:0] L90  = (ANG_W + 1)'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W:0] L180 = (ANG_W + 1)'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ANG_W:0] L360 = (ANG_W + 1)'(360 << ANGLE_FRAC_BITS);
    localparam logic [SQ_W-1:0]       ONE_SQ = SQ_W'(1) << (2 * UNIT_SHIFT);

    logic            ce;
    logic [PIPE-1:0] vld_reg;
    logic            m_tvalid_reg;
    logic [TD_W-1:0] m_tdata_reg, m_tdata_next;

    q2e_carry_t      mat;
    q2e_carry_t      sq_carry_reg;
    logic [SQ_W-1:0] sq_reg;
    logic signed [2*S_W-1:0] sq_full;

    q2e_sqrt_t   sq_st [0:SQRT_STEPS];
    q2e_carry_t  cr_st [0:SQRT_STEPS];
    q2e_cordic_t cs    [0:2][0:NSTG];
    q2e_cordic_t pre_reg [0:2];
    q2e_cordic_t pre_next [0:2];

    logic signed [ANG_W-1:0] zr [0:2];
    logic signed [ANG_W:0]   roll_q, pitch_q, yaw_q;
    logic signed [ANG_W:0]   roll_c, pitch_c, yaw_c;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg      <= {vld_reg[PIPE-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE-1];
        end
    end

    q2e_matrix u_matrix (
        .aclk   (aclk),
        .ce     (ce),
        .quat_w (s_tdata[15:0]),
        .quat_x (s_tdata[31:16]),
        .quat_y (s_tdata[47:32]),
        .quat_z (s_tdata[63:48]),
        .mat    (mat)
    );

    assign sq_full = mat.s * mat.s;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_reg       <= sq_full[SQ_W-1:0];
            sq_carry_reg <= mat;
        end
    end

    assign sq_st[0].rem = ONE_SQ - sq_reg;
    assign sq_st[0].res = '0;
    assign cr_st[0]     = sq_carry_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        q2e_sqrt_cell #(.BIT_POS(2 * (SQRT_STEPS - 1 - k))) u_cell (
            .aclk      (aclk),
            .ce        (ce),
            .sq_in     (sq_st[k]),
            .carry_in  (cr_st[k]),
            .sq_out    (sq_st[k+1]),
            .carry_out (cr_st[k+1])
        );
    end

    always_comb begin
        pre_next[0] = prerot(CRD_W'(cr_st[SQRT_STEPS].a31), CRD_W'(cr_st[SQRT_STEPS].a33));
        pre_next[1] = prerot(CRD_W'(cr_st[SQRT_STEPS].s),
                             CRD_W'({1'b0, sq_st[SQRT_STEPS].res[S_W-2:0]}));
        pre_next[2] = prerot(CRD_W'(cr_st[SQRT_STEPS].a12), CRD_W'(cr_st[SQRT_STEPS].a22));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pre_reg <= pre_next;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        assign cs[ch][0] = pre_reg[ch];
        for (genvar i = 0; i < NSTG; i++) begin : g_stage
            q2e_cordic_cell #(.IDX(i)) u_cell (
                .aclk  (aclk),
                .ce    (ce),
                .c_in  (cs[ch][i]),
                .c_out (cs[ch][i+1])
            );
        end
        assign zr[ch] = cs[ch][NSTG].zero ? '0 : cs[ch][NSTG].z;
    end

    always_comb begin
        roll_q  = ((ANG_W + 1)'(zr[0]) + RND) >>> SH;
        pitch_q = (-(ANG_W + 1)'(zr[1]) + RND) >>> SH;
        yaw_q   = ((ANG_W + 1)'(zr[2]) + RND) >>> SH;

        if (roll_q > L180) begin
            roll_c = L180;
        end else if (roll_q < -L180) begin
            roll_c = -L180;
        end else begin
            roll_c = roll_q;
        end

        if (pitch_q > L90) begin
            pitch_c = L90;
        end else if (pitch_q < -L90) begin
            pitch_c = -L90;
        end else begin
            pitch_c = pitch_q;
        end

        if (yaw_q >= L180) begin
            yaw_c = yaw_q - L360;
        end else if (yaw_q < -L180) begin
            yaw_c = yaw_q + L360;
        end else begin
            yaw_c = yaw_q;
        end

        m_tdata_next                            = '0;
        m_tdata_next[ROLL_W-1:0]                = roll_c[ROLL_W-1:0];
        m_tdata_next[ROLL_W +: PITCH_W]         = pitch_c[PITCH_W-1:0];
        m_tdata_next[ROLL_W + PITCH_W +: YAW_W] = yaw_c[YAW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

// File: design/q2e_matrix.sv
module q2e_matrix
    import q2e_pkg::*;
(
    input  logic                   aclk,
    input  logic                   ce,
    input  logic signed [IN_W-1:0] quat_w,
    input  logic signed [IN_W-1:0] quat_x,
    input  logic signed [IN_W-1:0] quat_y,
    input  logic signed [IN_W-1:0] quat_z,
    output q2e_carry_t             mat
);

    localparam int P_W = 2 * IN_W;
    localparam logic signed [MAT_W-1:0] ONE_P = MAT_W'(1) <<< UNIT_SHIFT;

    logic signed [P_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [P_W-1:0] xy_reg, wz_reg, wx_reg, yz_reg, xz_reg, wy_reg;
    q2e_carry_t            mat_reg;
    q2e_carry_t            mat_next;
    logic signed [MAT_W-1:0] a32;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            wz_reg <= quat_w * quat_z;
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xz_reg <= quat_x * quat_z;
            wy_reg <= quat_w * quat_y;
        end
    end

    always_comb begin
        mat_next.a12 = (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
        mat_next.a22 = MAT_W'(ww_reg) + MAT_W'(xx_reg) - MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next.a31 = (MAT_W'(wx_reg) + MAT_W'(yz_reg)) <<< 1;
        mat_next.a33 = MAT_W'(ww_reg) - MAT_W'(xx_reg) - MAT_W'(yy_reg) + MAT_W'(zz_reg);
        a32          = (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
        if (a32 > ONE_P) begin
            mat_next.s = S_W'(ONE_P);
        end else if (a32 < -ONE_P) begin
            mat_next.s = S_W'(-ONE_P);
        end else begin
            mat_next.s = S_W'(a32);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

// File: design/q2e_sqrt_cell.sv
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int BIT_POS = 56
) (
    input  logic       aclk,
    input  logic       ce,
    input  q2e_sqrt_t  sq_in,
    input  q2e_carry_t carry_in,
    output q2e_sqrt_t  sq_out,
    output q2e_carry_t carry_out
);

    localparam logic [SQ_W:0] BIT_V = (SQ_W + 1)'(1) << BIT_POS;

    q2e_sqrt_t  sq_reg, sq_next;
    q2e_carry_t carry_reg;
    logic [SQ_W:0] trial;

    always_comb begin
        trial = {1'b0, sq_in.res} + BIT_V;
        if ({1'b0, sq_in.rem} >= trial) begin
            sq_next.rem = SQ_W'({1'b0, sq_in.rem} - trial);
            sq_next.res = SQ_W'({2'b00, sq_in.res[SQ_W-1:1]} + BIT_V);
        end else begin
            sq_next.rem = sq_in.rem;
            sq_next.res = {1'b0, sq_in.res[SQ_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_reg    <= sq_next;
            carry_reg <= carry_in;
        end
    end

    assign sq_out    = sq_reg;
    assign carry_out = carry_reg;

endmodule

// File: design/q2e_cordic_cell.sv
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        aclk,
    input  logic        ce,
    input  q2e_cordic_t c_in,
    output q2e_cordic_t c_out
);

    localparam logic signed [ANG_W-1:0] T_I = atan_tab(IDX);

    q2e_cordic_t c_reg, c_next;
    logic signed [CRD_W-1:0] xs, ys;

    always_comb begin
        xs          = c_in.x >>> IDX;
        ys          = c_in.y >>> IDX;
        c_next.zero = c_in.zero;
        if (!c_in.y[CRD_W-1]) begin
            c_next.x = c_in.x + ys;
            c_next.y = c_in.y - xs;
            c_next.z = c_in.z + T_I;
        end else begin
            c_next.x = c_in.x - ys;
            c_next.y = c_in.y + xs;
            c_next.z = c_in.z - T_I;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

// File: design/q2e_checker.sv
`include "assert_macros.svh"

module q2e_checker #(
    parameter int ANGLE_FRAC_BITS = 6,
    localparam int ROLL_W  = 9 + ANGLE_FRAC_BITS,
    localparam int PITCH_W = 8 + ANGLE_FRAC_BITS,
    localparam int YAW_W   = 9 + ANGLE_FRAC_BITS,
    localparam int TD_W    = ((ROLL_W + PITCH_W + YAW_W + 7) / 8) * 8
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [TD_W-1:0] m_tdata
);

    localparam logic signed [YAW_W:0] L180 = (YAW_W + 1)'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [YAW_W:0] L90  = (YAW_W + 1)'(90 << ANGLE_FRAC_BITS);

    logic signed [YAW_W:0] yaw_v, pitch_v;

    assign yaw_v   = (YAW_W + 1)'($signed(m_tdata[ROLL_W + PITCH_W +: YAW_W]));
    assign pitch_v = (YAW_W + 1)'($signed(m_tdata[ROLL_W +: PITCH_W]));

    `Q2E_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `Q2E_ASSERT_IMPL(a_idle_ready, aclk, aresetn, !m_tvalid, s_tready)
    `Q2E_ASSERT_IMPL(a_drain_ready, aclk, aresetn, m_tvalid && m_tready, s_tready)
    `Q2E_ASSERT_IMPL(a_yaw_range, aclk, aresetn, m_tvalid, (yaw_v < L180) && (yaw_v >= -L180))
    `Q2E_ASSERT_IMPL(a_pitch_range, aclk, aresetn, m_tvalid, (pitch_v <= L90) && (pitch_v >= -L90))

endmodule

bind quaternion_to_euler q2e_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_q2e_checker (.*);

// File: tb/tb.sv
module tb;
    import q2e_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB      = ANGLE_FRAC_BITS_DEF;
    localparam int ROLL_W  = 9 + FB;
    localparam int PITCH_W = 8 + FB;
    localparam int YAW_W   = 9 + FB;
    localparam int TD_W    = ((ROLL_W + PITCH_W + YAW_W + 7) / 8) * 8;
    localparam int LATENCY = 34 + CORDIC_STAGES_DEF;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [YAW_W-1:0]   yaw;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
    } angles_t;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [63:0]     s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [TD_W-1:0] m_tdata;
    logic            s_tready_q;

    logic [63:0] quat_q[$];
    angles_t     angles_q[$];
    int          errors;
    int          n_sent;
    int          n_recv;
    longint      cycle;
    bit          idle_on;
    bit          hold_off;
    bit          done_sending;

    quaternion_to_euler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint floor_shr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint atan2_deg(longint y, longint x);
        longint xr, yr, z, xs, ys;
        if (x == 0 && y == 0) return 0;
        if (y >= 0) begin
            xr = y; yr = -x; z = 90 * (64'sd1 << ANG_BITS);
        end else begin
            xr = -y; yr = x; z = -90 * (64'sd1 << ANG_BITS);
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
            xs = floor_shr(xr, i);
            ys = floor_shr(yr, i);
            if (yr >= 0) begin
                xr = xr + ys; yr = yr - xs; z += longint'(atan_tab(i));
            end else begin
                xr = xr - ys; yr = yr + xs; z -= longint'(atan_tab(i));
            end
        end
        return z;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint to_units(longint z);
        int sh;
        sh = ANG_BITS - FB;
        return floor_shr(z + (64'sd1 << (sh - 1)), sh);
    endfunction

    function automatic longint lim(longint v, longint l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic angles_t euler_of(logic [63:0] q);
        longint w, x, y, z, a12, a22, a31, a32, a33, c, half, yw;
        angles_t r;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        half = 180 * (64'sd1 << FB);
        a12 = 2 * (x * y + w * z);
        a22 = w * w + x * x - y * y - z * z;
        a31 = 2 * (w * x + y * z);
        a32 = lim(2 * (x * z - w * y), 64'sd1 << UNIT_SHIFT);
        a33 = w * w - x * x - y * y + z * z;
        c = isqrt((64'd1 << 56) - longint'(a32 * a32));
        r.roll  = ROLL_W'(lim(to_units(atan2_deg(a31, a33)), half));
        r.pitch = PITCH_W'(lim(to_units(-atan2_deg(a32, c)), 90 * (64'sd1 << FB)));
        yw = to_units(atan2_deg(a12, a22));
        if (yw >= half) yw -= 2 * half;
        else if (yw < -half) yw += 2 * half;
        r.yaw = YAW_W'(yw);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at cycle %0d, result %0d: %s got %0d expected %0d",
                 cycle, n_recv, what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_q) begin
            if (quat_q.size() > 0 && !hold_off &&
                    (!idle_on || $urandom_range(99) >= 25)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= quat_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !idle_on || $urandom_range(99) >= 25;
    end

    // transfer seen at the rising edge; popped here so the driver sees the next head
    always @(posedge aclk) begin
        s_tready_q <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            angles_q.push_back(euler_of(s_tdata));
            void'(quat_q.pop_front());
            n_sent++;
        end
    end

    // monitor
    always @(posedge aclk) begin
        angles_t got, want;
        cycle <= cycle + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = angles_t'(m_tdata[ROLL_W+PITCH_W+YAW_W-1:0]);
            if (angles_q.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle);
                errors++;
            end else begin
                want = angles_q.pop_front();
                if (got.roll != want.roll) report("roll", got.roll, want.roll);
                if (got.pitch != want.pitch) report("pitch", got.pitch, want.pitch);
                if (got.yaw != want.yaw) report("yaw", got.yaw, want.yaw);
            end
            n_recv++;
        end
    end

    function automatic logic [15:0] rnd_comp();
        case ($urandom_range(5))
            0: return 16'h8000 + 16'($urandom_range(3));
            1: return 16'h7FFF - 16'($urandom_range(3));
            2: return 16'($urandom_range(7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // random unit quaternion in Q2.14, scaled by a random factor between 0.97 and 1.03
    function automatic logic [63:0] unit_quat();
        real c[4], n, s;
        logic [63:0] q;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            c[i] = real'($signed(16'($urandom))) / 32768.0;
            n += c[i] * c[i];
        end
        if (n < 1e-6) return 64'h0000_0000_0000_4000;
        s = 16384.0 * (0.97 + 0.06 * real'($urandom_range(1000)) / 1000.0) / $sqrt(n);
        for (int i = 0; i < 4; i++) q[16*i +: 16] = 16'($rtoi(c[i] * s));
        return q;
    endfunction

    initial begin
        logic [63:0] v;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        s_tready_q = 1'b0;
        errors = 0; n_sent = 0; n_recv = 0; cycle = 0;
        idle_on = 1'b0; hold_off = 1'b0; done_sending = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // identity, zero, extremes, gimbal lock both ways, half turns
        quat_q.push_back(64'h0000_0000_0000_4000);
        quat_q.push_back(64'h0000_0000_0000_0000);
        quat_q.push_back(64'h7FFF_7FFF_7FFF_7FFF);
        quat_q.push_back(64'h8000_8000_8000_8000);
        quat_q.push_back(64'h8000_7FFF_8000_7FFF);
        quat_q.push_back(64'h7FFF_8000_7FFF_8000);
        quat_q.push_back(64'h0000_2D41_0000_2D41);
        quat_q.push_back(64'h0000_D2BF_0000_2D41);
        quat_q.push_back(64'h2000_E000_2000_2000);
        quat_q.push_back(64'h2000_2000_E000_2000);
        quat_q.push_back(64'h4000_0000_0000_0000);
        quat_q.push_back(64'h0000_4000_0000_0000);
        quat_q.push_back(64'h0000_0000_4000_0000);
        quat_q.push_back(64'h0000_0000_C000_0000);
        quat_q.push_back(64'h0000_0001_0000_0000);
        quat_q.push_back(64'hFFFF_0000_0000_0000);
        quat_q.push_back(64'h0000_0000_0000_C000);
        quat_q.push_back(64'h0001_0000_0000_0000);
        quat_q.push_back(64'h0000_0000_0000_7FFF);
        quat_q.push_back(64'h0000_0000_0000_8000);
        wait (quat_q.size() == 0);

        // no idling first, then random gaps
        for (int i = 0; i < 200; i++) quat_q.push_back(unit_quat());
        wait (quat_q.size() == 0);
        idle_on = 1'b1;
        for (int i = 0; i < 400; i++) begin
            v = ($urandom_range(3) == 0) ? {rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()}
                                         : unit_quat();
            quat_q.push_back(v);
            if (i == 200) begin
                wait (quat_q.size() == 0);
                hold_off = 1'b1;
                wait (angles_q.size() == 0);
                hold_off = 1'b0;
            end
        end
        wait (quat_q.size() == 0);
        done_sending = 1'b1;
    end

    initial begin
        wait (done_sending);
        wait (angles_q.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("%0d quaternions sent and %0d angle sets checked, including", n_sent, n_recv);
        $display("axis turns, gimbal lock, saturating components and random rotations");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        wait (cycle >= LIMIT);
        $display("timeout after %0d cycles", cycle);
        $display("TEST FAILED");
        $finish;
    end

endmodule
